/* rtl/tbfc_pkg.sv */
`default_nettype none
package tbfc_pkg;

   // sizes
   localparam int MAX_TAPS     = 64;
   localparam int TAP_BITS     = $clog2(MAX_TAPS);
   localparam int CNT_BITS     = $clog2(MAX_TAPS + 1);
   localparam int SAMPLE_BITS  = 16;
   localparam int COEF_BITS    = 16;
   localparam int PROD_BITS    = SAMPLE_BITS + COEF_BITS;
   localparam int ACC_BITS     = PROD_BITS + TAP_BITS + 2;
   localparam int QUOT_BITS    = ACC_BITS - COEF_BITS + 1;
   localparam int CADDR_BITS   = TAP_BITS + 1;
   localparam int COEF_DEPTH   = 2 * MAX_TAPS;
   localparam int BUILTIN_TAPS = 17;
   localparam int BUILTIN_BITS = $clog2(BUILTIN_TAPS);

   // configuration port
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;
   localparam int TAPS_REG_BITS  = 7;
   localparam int ACTIVE_BITS    = 2;

   localparam logic [CSR_INDEX_BITS-1:0] REG_COEF_ADDRESS   = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_COEF_VALUE     = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_TAPS_LOW       = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_TAPS_HIGH      = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_ACTIVE_OUTPUTS = 3'd4;

   localparam logic [TAPS_REG_BITS-1:0] TAPS_RESET   = 7'd17;
   localparam logic [ACTIVE_BITS-1:0]   ACTIVE_RESET = 2'd2;

   // built-in crossover filters, Q1.15
   localparam logic signed [COEF_BITS-1:0] BUILTIN_LOW [BUILTIN_TAPS] = '{
      -16'sd92, -16'sd171, -16'sd261, -16'sd88, 16'sd724, 16'sd2325, 16'sd4382,
      16'sd6145, 16'sd6842, 16'sd6145, 16'sd4382, 16'sd2325, 16'sd724, -16'sd88,
      -16'sd261, -16'sd171, -16'sd92
   };
   localparam logic signed [COEF_BITS-1:0] BUILTIN_HIGH [BUILTIN_TAPS] = '{
      16'sd91, 16'sd169, 16'sd258, 16'sd87, -16'sd717, -16'sd2303, -16'sd4342,
      -16'sd6089, 16'sd25914, -16'sd6089, -16'sd4342, -16'sd2303, -16'sd717,
      16'sd87, 16'sd258, 16'sd169, 16'sd91
   };

   // reset value of a coefficient table entry
   function automatic logic signed [COEF_BITS-1:0] builtin_coef(
      input logic [CADDR_BITS-1:0] addr
   );
      logic [TAP_BITS-1:0]     tap;
      logic [BUILTIN_BITS-1:0] idx;
      logic signed [COEF_BITS-1:0] value;
      tap   = addr[TAP_BITS-1:0];
      idx   = tap[BUILTIN_BITS-1:0];
      value = '0;
      if (32'(tap) < BUILTIN_TAPS) begin
         value = addr[TAP_BITS] ? BUILTIN_HIGH[idx] : BUILTIN_LOW[idx];
      end
      return value;
   endfunction

   // sequencer steps
   localparam int STEP_BITS = 4;
   localparam logic [STEP_BITS-1:0] STEP_WAIT         = 4'd0;
   localparam logic [STEP_BITS-1:0] STEP_MAC_LOW      = 4'd1;
   localparam logic [STEP_BITS-1:0] STEP_DRAIN_LOW_A  = 4'd2;
   localparam logic [STEP_BITS-1:0] STEP_DRAIN_LOW_B  = 4'd3;
   localparam logic [STEP_BITS-1:0] STEP_ROUND_LOW    = 4'd4;
   localparam logic [STEP_BITS-1:0] STEP_MAC_HIGH     = 4'd5;
   localparam logic [STEP_BITS-1:0] STEP_DRAIN_HIGH_A = 4'd6;
   localparam logic [STEP_BITS-1:0] STEP_DRAIN_HIGH_B = 4'd7;
   localparam logic [STEP_BITS-1:0] STEP_ROUND_HIGH   = 4'd8;
   localparam logic [STEP_BITS-1:0] STEP_PUBLISH      = 4'd9;

   // jump conditions: jump to target when true, else hold the step
   localparam logic [1:0] COND_ALWAYS    = 2'd0;
   localparam logic [1:0] COND_ACCEPT    = 2'd1;
   localparam logic [1:0] COND_LOOP_DONE = 2'd2;
   localparam logic [1:0] COND_OUT_FREE  = 2'd3;

   typedef struct packed {
      logic [1:0]           cond;
      logic [STEP_BITS-1:0] target;
      logic                 issue;
      logic                 clear;
      logic                 band;
      logic                 store_low;
      logic                 store_high;
      logic                 publish;
   } ucode_type;

   // control store
   function automatic ucode_type ucode_rom(input logic [STEP_BITS-1:0] step);
      ucode_type word;
      word        = '0;
      word.cond   = COND_ALWAYS;
      word.target = STEP_WAIT;
      case (step)
         STEP_WAIT: begin
            word.cond   = COND_ACCEPT;
            word.target = STEP_MAC_LOW;
            word.clear  = 1'b1;
         end
         STEP_MAC_LOW: begin
            word.cond   = COND_LOOP_DONE;
            word.target = STEP_DRAIN_LOW_A;
            word.issue  = 1'b1;
         end
         STEP_DRAIN_LOW_A: word.target = STEP_DRAIN_LOW_B;
         STEP_DRAIN_LOW_B: word.target = STEP_ROUND_LOW;
         STEP_ROUND_LOW: begin
            word.target    = STEP_MAC_HIGH;
            word.store_low = 1'b1;
            word.clear     = 1'b1;
         end
         STEP_MAC_HIGH: begin
            word.cond   = COND_LOOP_DONE;
            word.target = STEP_DRAIN_HIGH_A;
            word.issue  = 1'b1;
            word.band   = 1'b1;
         end
         STEP_DRAIN_HIGH_A: word.target = STEP_DRAIN_HIGH_B;
         STEP_DRAIN_HIGH_B: word.target = STEP_ROUND_HIGH;
         STEP_ROUND_HIGH: begin
            word.target     = STEP_PUBLISH;
            word.store_high = 1'b1;
         end
         STEP_PUBLISH: begin
            word.cond    = COND_OUT_FREE;
            word.target  = STEP_WAIT;
            word.publish = 1'b1;
         end
         default: word.target = STEP_WAIT;
      endcase
      return word;
   endfunction

endpackage
`default_nettype wire

/* rtl/tbfc_ram.sv */
`default_nettype none
module tbfc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* rtl/two_band_fir_crossover.sv */
// Processing: the single shared MAC takes one tap a cycle under control of the step program,
// first over the taps in use for the low band, then for the high band (an inactive band uses
// none); a new input is taken only while the program waits, so one item is in work at a time.
// Reset: synchronous, active high; clears the history and coefficient valid bits (history
// reads as zero, coefficients as built-in filters) and the pointer; resets CSRs and handshakes.
`default_nettype none
module two_band_fir_crossover (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    req_valid,
   output      logic                                    req_stall,
   input  wire logic signed [tbfc_pkg::SAMPLE_BITS-1:0] req_sample_in,
   output      logic                                    rsp_valid,
   input  wire logic                                    rsp_stall,
   output      logic signed [tbfc_pkg::SAMPLE_BITS-1:0] rsp_low_out,
   output      logic signed [tbfc_pkg::SAMPLE_BITS-1:0] rsp_high_out,
   output      logic                                    rsp_low_clipped,
   output      logic                                    rsp_high_clipped,
   input  wire logic                                    csr_valid,
   output      logic                                    csr_ready,
   input  wire logic [tbfc_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  wire logic [tbfc_pkg::CSR_DATA_BITS-1:0]      csr_data
);

   localparam int SB = tbfc_pkg::SAMPLE_BITS;
   localparam int CB = tbfc_pkg::COEF_BITS;
   localparam int TB = tbfc_pkg::TAP_BITS;
   localparam int NB = tbfc_pkg::CNT_BITS;
   localparam int AB = tbfc_pkg::ACC_BITS;
   localparam int PB = tbfc_pkg::PROD_BITS;
   localparam int QB = tbfc_pkg::QUOT_BITS;
   localparam int CAB = tbfc_pkg::CADDR_BITS;

   // configuration registers
   logic [CAB-1:0]                      coef_address_ff;
   logic [tbfc_pkg::TAPS_REG_BITS-1:0]  taps_low_ff;
   logic [tbfc_pkg::TAPS_REG_BITS-1:0]  taps_high_ff;
   logic [tbfc_pkg::ACTIVE_BITS-1:0]    active_ff;
   logic                                csr_xfer;
   logic                                coef_wr;

   assign csr_ready = 1'b1;
   assign csr_xfer  = csr_valid && csr_ready;
   assign coef_wr   = csr_xfer && (csr_index == tbfc_pkg::REG_COEF_VALUE);

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_address_ff <= '0;
         taps_low_ff     <= tbfc_pkg::TAPS_RESET;
         taps_high_ff    <= tbfc_pkg::TAPS_RESET;
         active_ff       <= tbfc_pkg::ACTIVE_RESET;
      end else if (csr_xfer) begin
         case (csr_index)
            tbfc_pkg::REG_COEF_ADDRESS:   coef_address_ff <= csr_data[CAB-1:0];
            tbfc_pkg::REG_TAPS_LOW:       taps_low_ff <= csr_data[tbfc_pkg::TAPS_REG_BITS-1:0];
            tbfc_pkg::REG_TAPS_HIGH:      taps_high_ff <= csr_data[tbfc_pkg::TAPS_REG_BITS-1:0];
            tbfc_pkg::REG_ACTIVE_OUTPUTS: active_ff <= csr_data[tbfc_pkg::ACTIVE_BITS-1:0];
            default: ;
         endcase
      end
   end

   // sequencer
   logic [tbfc_pkg::STEP_BITS-1:0] upc_ff, upc_in;
   tbfc_pkg::ucode_type            word;
   logic                           req_xfer;
   logic                           out_free;
   logic                           loop_done;
   logic                           cond_true;
   logic [NB-1:0]                  j_ff, j_in;
   logic [NB-1:0]                  n_eff;
   logic [tbfc_pkg::TAPS_REG_BITS-1:0] taps_sel;
   logic                           band_active;
   logic                           issue;

   assign word      = tbfc_pkg::ucode_rom(upc_ff);
   assign req_stall = (upc_ff != tbfc_pkg::STEP_WAIT);
   assign req_xfer  = req_valid && !req_stall;
   assign out_free  = !rsp_valid || !rsp_stall;

   // effective tap count of the band in the current step
   always_comb begin
      taps_sel    = word.band ? taps_high_ff : taps_low_ff;
      band_active = word.band ? (active_ff >= 2'd2) : (active_ff >= 2'd1);
      if (!band_active) begin
         n_eff = '0;
      end else if (32'(taps_sel) > tbfc_pkg::MAX_TAPS) begin
         n_eff = NB'(tbfc_pkg::MAX_TAPS);
      end else begin
         n_eff = NB'(taps_sel);
      end
   end

   assign issue     = word.issue && (j_ff < n_eff);
   assign loop_done = ((j_ff + NB'(1)) >= n_eff);

   always_comb begin
      case (word.cond)
         tbfc_pkg::COND_ALWAYS:    cond_true = 1'b1;
         tbfc_pkg::COND_ACCEPT:    cond_true = req_xfer;
         tbfc_pkg::COND_LOOP_DONE: cond_true = loop_done;
         tbfc_pkg::COND_OUT_FREE:  cond_true = out_free;
         default:                  cond_true = 1'b0;
      endcase
      upc_in = cond_true ? word.target : upc_ff;
      if (word.clear) begin
         j_in = '0;
      end else if (issue) begin
         j_in = j_ff + NB'(1);
      end else begin
         j_in = j_ff;
      end
   end

   // write pointer and history valid bits
   logic [TB-1:0]             wp_ff, wp_in;
   logic [tbfc_pkg::MAX_TAPS-1:0]  hist_valid_ff;
   logic [tbfc_pkg::COEF_DEPTH-1:0] coef_valid_ff;
   logic                      publish;

   assign publish = word.publish && cond_true;
   assign wp_in   = publish ? wp_ff + TB'(1) : wp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff        <= tbfc_pkg::STEP_WAIT;
         j_ff          <= '0;
         wp_ff         <= '0;
         hist_valid_ff <= '0;
         coef_valid_ff <= '0;
      end else begin
         upc_ff <= upc_in;
         j_ff   <= j_in;
         wp_ff  <= wp_in;
         if (req_xfer) begin
            hist_valid_ff[wp_ff] <= 1'b1;
         end
         if (coef_wr) begin
            coef_valid_ff[coef_address_ff] <= 1'b1;
         end
      end
   end

   // history and coefficient memories
   logic [TB-1:0]  hist_rd_addr;
   logic [CAB-1:0] coef_rd_addr;
   logic [SB-1:0]  hist_rdata;
   logic [CB-1:0]  coef_rdata;

   assign hist_rd_addr = wp_ff - j_ff[TB-1:0];
   assign coef_rd_addr = {word.band, j_ff[TB-1:0]};

   tbfc_ram #(
      .WIDTH (SB),
      .DEPTH (tbfc_pkg::MAX_TAPS)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (req_xfer),
      .wr_addr (wp_ff),
      .wr_data (req_sample_in),
      .rd_addr (hist_rd_addr),
      .rd_data (hist_rdata)
   );

   tbfc_ram #(
      .WIDTH (CB),
      .DEPTH (tbfc_pkg::COEF_DEPTH)
   ) u_coef_ram (
      .clock   (clock),
      .wr_en   (coef_wr),
      .wr_addr (coef_address_ff),
      .wr_data (csr_data[CB-1:0]),
      .rd_addr (coef_rd_addr),
      .rd_data (coef_rdata)
   );

   // mac pipeline: read, multiply, accumulate
   logic                 s1_live_ff;
   logic                 s1_hval_ff;
   logic                 s1_cval_ff;
   logic signed [CB-1:0] s1_cdef_ff;
   logic                 s2_live_ff;
   logic signed [SB-1:0] mul_a;
   logic signed [CB-1:0] mul_b;
   logic signed [PB-1:0] prod_ff, prod_in;
   logic signed [AB-1:0] acc_ff, acc_in;

   assign mul_a   = s1_hval_ff ? signed'(hist_rdata) : '0;
   assign mul_b   = s1_cval_ff ? signed'(coef_rdata) : s1_cdef_ff;
   assign prod_in = mul_a * mul_b;

   always_comb begin
      if (word.clear) begin
         acc_in = '0;
      end else if (s2_live_ff) begin
         acc_in = acc_ff + {{(AB - PB){prod_ff[PB-1]}}, prod_ff};
      end else begin
         acc_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_live_ff <= 1'b0;
         s2_live_ff <= 1'b0;
      end else begin
         s1_live_ff <= issue;
         s2_live_ff <= s1_live_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_hval_ff <= hist_valid_ff[hist_rd_addr];
      s1_cval_ff <= coef_valid_ff[coef_rd_addr];
      s1_cdef_ff <= tbfc_pkg::builtin_coef(coef_rd_addr);
      prod_ff    <= prod_in;
      acc_ff     <= acc_in;
   end

   // round half up, then saturate
   logic [AB-1:0]        sum_r;
   logic [QB-1:0]        quot;
   logic                 clip_hi;
   logic                 clip_lo;
   logic signed [SB-1:0] band_res;
   logic                 band_clip;

   always_comb begin
      sum_r   = acc_ff + (AB'(1) << (CB - 2));
      quot    = sum_r[AB-1:CB-1];
      clip_hi = !quot[QB-1] && (quot[QB-1:SB-1] != '0);
      clip_lo = quot[QB-1] && (quot[QB-1:SB-1] != '1);
      if (clip_hi) begin
         band_res = {1'b0, {(SB - 1){1'b1}}};
      end else if (clip_lo) begin
         band_res = {1'b1, {(SB - 1){1'b0}}};
      end else begin
         band_res = signed'(quot[SB-1:0]);
      end
      band_clip = clip_hi || clip_lo;
   end

   // band results and output register
   logic signed [SB-1:0] low_res_ff, high_res_ff;
   logic                 low_clip_ff, high_clip_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [SB-1:0] rsp_low_ff, rsp_high_ff;
   logic                 rsp_low_clip_ff, rsp_high_clip_ff;

   always_ff @(posedge clock) begin
      if (word.store_low) begin
         low_res_ff  <= band_res;
         low_clip_ff <= band_clip;
      end
      if (word.store_high) begin
         high_res_ff  <= band_res;
         high_clip_ff <= band_clip;
      end
      if (publish) begin
         rsp_low_ff       <= low_res_ff;
         rsp_high_ff      <= high_res_ff;
         rsp_low_clip_ff  <= low_clip_ff;
         rsp_high_clip_ff <= high_clip_ff;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (publish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_low_out      = rsp_low_ff;
   assign rsp_high_out     = rsp_high_ff;
   assign rsp_low_clipped  = rsp_low_clip_ff;
   assign rsp_high_clipped = rsp_high_clip_ff;

endmodule
`default_nettype wire

/* rtl/tbfc_checker.sv */
`default_nettype none
module tbfc_checker (
   input wire logic                                    clock,
   input wire logic                                    reset,
   input wire logic                                    req_valid,
   input wire logic                                    req_stall,
   input wire logic                                    rsp_valid,
   input wire logic                                    rsp_stall,
   input wire logic signed [tbfc_pkg::SAMPLE_BITS-1:0] rsp_low_out,
   input wire logic signed [tbfc_pkg::SAMPLE_BITS-1:0] rsp_high_out,
   input wire logic                                    rsp_low_clipped,
   input wire logic                                    rsp_high_clipped
);

   localparam int SB = tbfc_pkg::SAMPLE_BITS;
   localparam logic [SB-1:0] POS_FULL = {1'b0, {(SB - 1){1'b1}}};
   localparam logic [SB-1:0] NEG_FULL = {1'b1, {(SB - 1){1'b0}}};

   logic req_xfer;

   assign req_xfer = req_valid && !req_stall;

   // a held result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_low_out) && $stable(rsp_high_out)
         && $stable(rsp_low_clipped) && $stable(rsp_high_clipped))
      else $error("result changed while stalled");

   // one item in work at a time
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> req_stall)
      else $error("second item taken while busy");

   // no new result in the first cycles after a transfer in
   a_min_latency: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> !$rose(rsp_valid) ##1 !$rose(rsp_valid) ##1 !$rose(rsp_valid))
      else $error("result too early");

   // a clip flag comes with a full-scale value
   a_clip_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_low_clipped || rsp_low_out == POS_FULL || rsp_low_out == NEG_FULL)
         && (!rsp_high_clipped || rsp_high_out == POS_FULL || rsp_high_out == NEG_FULL))
      else $error("clip flag without saturated value");

endmodule

bind two_band_fir_crossover tbfc_checker u_tbfc_checker (.*);
`default_nettype wire
